/* rtl/core/swsg_pkg.sv */
// Shared types and constants for the standard waveform sample generator.
`default_nettype none
package swsg_pkg;

  // field and datapath widths
  localparam int LEN_W = 13;
  localparam int IDX_W = 12;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;
  localparam int Q_W = 17;                 // quotient, up to 65536
  localparam int NUM_W = IDX_W + Q_W;      // dividend, below len * 2^17

  localparam logic [LEN_W-1:0] MAX_TABLE_LENGTH = 13'd4096;
  localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 13'd64;

  // wave type codes
  localparam logic [TYPE_W-1:0] WAVE_SINE = 3'd0;
  localparam logic [TYPE_W-1:0] WAVE_SAW_UP = 3'd1;
  localparam logic [TYPE_W-1:0] WAVE_SAW_DOWN = 3'd2;
  localparam logic [TYPE_W-1:0] WAVE_SQUARE = 3'd3;
  localparam logic [TYPE_W-1:0] WAVE_TRIANGLE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_TYPE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // quarter-sine polynomial coefficients, Q1.30
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  // per-word info carried beside the divider
  typedef struct packed {
    logic [TYPE_W-1:0] wave_type;
    logic [STAT_W-1:0] status;
    logic              sq_high;   // square: first half of the cycle
  } side_t;

endpackage
`default_nettype wire

/* rtl/core/swsg_div.sv */
// Pipelined restoring divider: 17 quotient bits, four bits per stage, one bit in the last stage.
`default_nettype none
module swsg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [swsg_pkg::NUM_W-1:0]    in_num,
  input  wire swsg_pkg::side_t               in_side,
  input  wire logic [swsg_pkg::LEN_W-1:0]    div_len,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [swsg_pkg::Q_W-1:0]           out_q,
  output swsg_pkg::side_t                    out_side
);

  localparam int LW = swsg_pkg::LEN_W;
  localparam int QW = swsg_pkg::Q_W;
  localparam int STEP = 4;
  localparam int NSTG = (QW + STEP - 1) / STEP;

  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] v_r;
  logic [LW-1:0]   rem_r [NSTG];
  logic [QW-1:0]   low_r [NSTG];
  logic [QW-1:0]   q_r   [NSTG];
  swsg_pkg::side_t side_r [NSTG];

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int NB = (QW - k * STEP < STEP) ? (QW - k * STEP) : STEP;

    logic [LW-1:0]   rem_in, rem_c;
    logic [QW-1:0]   low_in, low_c, q_in, q_c;
    logic [LW:0]     remx;
    swsg_pkg::side_t side_in;
    logic            v_in;

    // stage source: the input port or the stage before
    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, in_num[swsg_pkg::NUM_W-1:QW]};
      assign low_in  = in_num[QW-1:0];
      assign q_in    = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // NB shift-compare-subtract steps
    always_comb begin
      rem_c = rem_in;
      low_c = low_in;
      q_c   = q_in;
      remx  = '0;
      for (int j = 0; j < NB; j++) begin
        remx  = {rem_c, low_c[QW-1]};
        low_c = {low_c[QW-2:0], 1'b0};
        if (remx >= {1'b0, div_len}) begin
          rem_c = LW'(remx - {1'b0, div_len});
          q_c   = {q_c[QW-2:0], 1'b1};
        end else begin
          rem_c = remx[LW-1:0];
          q_c   = {q_c[QW-2:0], 1'b0};
        end
      end
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
      if (rdy[k]) begin
        rem_r[k]  <= rem_c;
        low_r[k]  <= low_c;
        q_r[k]    <= q_c;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_q     = q_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule
`default_nettype wire

/* rtl/core/standard_waveform_sample_generator_unit.sv */
// Top level of the standard waveform sample generator.
`default_nettype none
// Takes one word (wave type, sample index) per cycle while the output is not stalled
// and returns one Q1.15 sample per word, in order: one input register, a five-stage
// pipelined divider by table_length (four quotient bits per stage, one in the last),
// then six stages for waveform shaping, the sine polynomial (one multiplier per stage)
// and output rounding. Sustained rate is one word per clock when the output is not
// stalled. table_length is clamped to 4096 on write and may only be changed
// while no word is in flight. Unknown types give status 1, indexes at or past the
// length give status 2; both return sample 0.
module standard_waveform_sample_generator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [12:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_wave_type,
  input  wire logic [11:0]        in_sample_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_sample_value,
  output logic [1:0]              out_status
);

  localparam int LW = swsg_pkg::LEN_W;
  localparam int QW = swsg_pkg::Q_W;
  localparam int NW = swsg_pkg::NUM_W;

  typedef struct packed {
    logic              is_sine;
    logic              neg;
    logic signed [15:0] val;
    logic [1:0]        status;
  } tail_t;

  function automatic logic signed [15:0] sat_pos(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sd32767;
    end
    return v[15:0];
  endfunction

  // table length register
  logic [LW-1:0] len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= swsg_pkg::TABLE_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      len_r <= (cfg_wr_data > swsg_pkg::MAX_TABLE_LENGTH) ? swsg_pkg::MAX_TABLE_LENGTH
                                                         : cfg_wr_data;
    end
  end

  // stage A: classify and build the dividend
  logic            a_v_r, a_rdy, div_in_ready;
  logic [NW-1:0]   a_num_r, num_nxt;
  swsg_pkg::side_t a_side_r, side_nxt;
  logic [LW:0]     diff;
  logic [LW-1:0]   absd;
  logic [LW-1:0]   idx2;

  always_comb begin
    idx2 = {in_sample_index, 1'b0};
    diff = {1'b0, idx2} - {1'b0, len_r};
    absd = diff[LW] ? LW'(-diff) : diff[LW-1:0];
    side_nxt.wave_type = in_wave_type;
    side_nxt.sq_high   = (idx2 < len_r);
    if (in_wave_type > swsg_pkg::WAVE_TRIANGLE) begin
      side_nxt.status = swsg_pkg::STAT_BAD_TYPE;
    end else if ({1'b0, in_sample_index} >= len_r) begin
      side_nxt.status = swsg_pkg::STAT_RANGE;
    end else begin
      side_nxt.status = swsg_pkg::STAT_OK;
    end
    case (in_wave_type)
      swsg_pkg::WAVE_SINE: num_nxt = {1'b0, in_sample_index, 16'b0};
      swsg_pkg::WAVE_TRIANGLE: num_nxt = NW'({absd, 16'b0}) + NW'(len_r >> 1);
      default: num_nxt = {1'b0, in_sample_index, 16'b0} + NW'(len_r >> 1);
    endcase
  end

  assign a_rdy    = !a_v_r || div_in_ready;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
    if (a_rdy) begin
      a_num_r  <= num_nxt;
      a_side_r <= side_nxt;
    end
  end

  // divider
  logic            div_out_valid, b_rdy;
  logic [QW-1:0]   div_q;
  swsg_pkg::side_t div_side;

  swsg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v_r),
    .in_ready  (div_in_ready),
    .in_num    (a_num_r),
    .in_side   (a_side_r),
    .div_len   (len_r),
    .out_valid (div_out_valid),
    .out_ready (b_rdy),
    .out_q     (div_q),
    .out_side  (div_side)
  );

  // stage B: shape saw/square/triangle, fold sine phase
  logic           b_v_r, c_rdy;
  logic [16:0]    b_x_r, x_nxt;
  tail_t          b_t_r, tail_nxt;
  logic signed [18:0] up, down;
  logic [14:0]    xr;

  always_comb begin
    up   = $signed({2'b0, div_q}) - 19'sd32768;
    down = 19'sd32768 - $signed({2'b0, div_q});
    xr   = div_q[14] ? (15'd16384 - {1'b0, div_q[13:0]}) : {1'b0, div_q[13:0]};
    x_nxt = {xr, 2'b0};
    tail_nxt.status  = div_side.status;
    tail_nxt.neg     = div_q[15];
    tail_nxt.is_sine = (div_side.status == swsg_pkg::STAT_OK) &&
                       (div_side.wave_type == swsg_pkg::WAVE_SINE);
    case (div_side.wave_type) inside
      swsg_pkg::WAVE_SAW_UP: tail_nxt.val = sat_pos(up);
      swsg_pkg::WAVE_SAW_DOWN, swsg_pkg::WAVE_TRIANGLE: tail_nxt.val = sat_pos(down);
      swsg_pkg::WAVE_SQUARE: tail_nxt.val = div_side.sq_high ? 16'sd32767 : 16'sh8000;
      default: tail_nxt.val = '0;
    endcase
    if (div_side.status != swsg_pkg::STAT_OK) begin
      tail_nxt.val = '0;
    end
  end

  assign b_rdy = !b_v_r || c_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= div_out_valid;
    end
    if (b_rdy) begin
      b_x_r <= x_nxt;
      b_t_r <= tail_nxt;
    end
  end

  // stage C: x^2
  logic        c_v_r, d_rdy;
  logic [16:0] c_x_r, c_x2_r;
  tail_t       c_t_r;
  logic [33:0] xx;
  assign xx    = b_x_r * b_x_r;
  assign c_rdy = !c_v_r || d_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
    if (c_rdy) begin
      c_x_r  <= b_x_r;
      c_x2_r <= xx[32:16];
      c_t_r  <= b_t_r;
    end
  end

  // stage D: t = B - x^2*C
  logic        d_v_r, e_rdy;
  logic [16:0] d_x_r, d_x2_r;
  logic [29:0] d_tc_r;
  tail_t       d_t_r;
  logic [43:0] pc;
  assign pc    = c_x2_r * swsg_pkg::SIN_C;
  assign d_rdy = !d_v_r || e_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_rdy) begin
      d_v_r <= c_v_r;
    end
    if (d_rdy) begin
      d_x_r  <= c_x_r;
      d_x2_r <= c_x2_r;
      d_tc_r <= swsg_pkg::SIN_B - 30'(pc[43:16]);
      d_t_r  <= c_t_r;
    end
  end

  // stage E: u = A - x^2*t
  logic        e_v_r, f_rdy;
  logic [16:0] e_x_r;
  logic [30:0] e_u_r;
  tail_t       e_t_r;
  logic [46:0] pt;
  assign pt    = d_x2_r * d_tc_r;
  assign e_rdy = !e_v_r || f_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_rdy) begin
      e_v_r <= d_v_r;
    end
    if (e_rdy) begin
      e_x_r <= d_x_r;
      e_u_r <= swsg_pkg::SIN_A - pt[46:16];
      e_t_r <= d_t_r;
    end
  end

  // stage F: y = x*u
  logic        f_v_r, g_rdy;
  logic [31:0] f_y_r;
  tail_t       f_t_r;
  logic [47:0] pu;
  assign pu    = e_x_r * e_u_r;
  assign f_rdy = !f_v_r || g_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= e_v_r;
    end
    if (f_rdy) begin
      f_y_r <= pu[47:16];
      f_t_r <= e_t_r;
    end
  end

  // stage G: round, saturate, sign, output register
  logic        g_v_r;
  logic signed [15:0] g_val_r, val_nxt, mag;
  logic [1:0]  g_st_r;
  logic [32:0] yr;
  always_comb begin
    yr  = {1'b0, f_y_r} + 33'd16384;
    mag = (yr[32:15] > 18'd32767) ? 16'sd32767 : $signed(yr[30:15]);
    if (f_t_r.is_sine) begin
      val_nxt = f_t_r.neg ? -mag : mag;
    end else begin
      val_nxt = f_t_r.val;
    end
  end

  assign g_rdy = !g_v_r || out_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (g_rdy) begin
      g_v_r <= f_v_r;
    end
    if (g_rdy) begin
      g_val_r <= val_nxt;
      g_st_r  <= f_t_r.status;
    end
  end

  assign out_valid        = g_v_r;
  assign out_sample_value = g_val_r;
  assign out_status       = g_st_r;

endmodule
`default_nettype wire

/* tb/standard_waveform_sample_generator_unit_checker.sv */
// Checker for the waveform sample generator: predicts each sample and compares results.
module standard_waveform_sample_generator_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_wave_type,
  input  logic [11:0]        in_sample_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_sample_value,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         status;
  } sample_t;

  logic [12:0] cur_length;
  sample_t     sample_queue[$];
  int          mismatch_count;

  // quarter-wave polynomial, x in Q0.16
  function automatic longint quarter_wave(longint x);
    longint x2, t, u, y, r;
    x2 = (x * x) >>> 16;
    t = longint'(swsg_pkg::SIN_B) - ((x2 * longint'(swsg_pkg::SIN_C)) >>> 16);
    u = longint'(swsg_pkg::SIN_A) - ((x2 * t) >>> 16);
    y = (x * u) >>> 16;
    r = (y + 16384) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic sample_t predict_sample(logic [2:0] wtype, logic [11:0] idx,
                                             logic [12:0] len);
    sample_t s;
    longint i, l, ramp, d, v, p, quad, r, x;
    i = idx;
    l = len;
    v = 0;
    s.status = swsg_pkg::STAT_OK;
    if (wtype > swsg_pkg::WAVE_TRIANGLE) s.status = swsg_pkg::STAT_BAD_TYPE;
    else if (i >= l) s.status = swsg_pkg::STAT_RANGE;
    else begin
      ramp = ((i << 16) + (l >> 1)) / l;
      case (wtype)
        swsg_pkg::WAVE_SINE: begin
          p = (i << 16) / l;
          quad = (p >> 14) & 3;
          r = p & 16'h3FFF;
          x = ((quad & 1) ? (16384 - r) : r) << 2;
          v = quarter_wave(x);
          if (quad & 2) v = -v;
        end
        swsg_pkg::WAVE_SAW_UP: v = ramp - 32768;
        swsg_pkg::WAVE_SAW_DOWN: v = 32768 - ramp;
        swsg_pkg::WAVE_SQUARE: v = (2 * i < l) ? 32767 : -32768;
        default: begin
          d = (4 * i >= 2 * l) ? (4 * i - 2 * l) : (2 * l - 4 * i);
          v = 32768 - (((d << 15) + (l >> 1)) / l);
        end
      endcase
      if (v > 32767) v = 32767;
    end
    s.value = v[15:0];
    return s;
  endfunction

  // track config, queue expectations, compare results
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      cur_length <= swsg_pkg::TABLE_LENGTH_RESET;
      fail_count <= 0;
      mismatch_count = 0;
      sample_queue.delete();
    end else begin
      if (cfg_wr_en)
        cur_length <= (cfg_wr_data > swsg_pkg::MAX_TABLE_LENGTH) ? swsg_pkg::MAX_TABLE_LENGTH
                                                                 : cfg_wr_data;
      if (in_valid && in_ready)
        sample_queue.push_back(predict_sample(in_wave_type, in_sample_index, cur_length));
      if (out_valid && out_ready) begin
        if (sample_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_count < 10)
            $display("unexpected word: value %0d status %0d", out_sample_value, out_status);
          mismatch_count++;
        end else begin
          want = sample_queue.pop_front();
          if (want.value !== out_sample_value || want.status !== out_status) begin
            fail_count <= fail_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       want.value, want.status, out_sample_value, out_status);
            mismatch_count++;
          end
        end
      end
    end
    pending_count <= sample_queue.size();
  end
endmodule

/* tb/standard_waveform_sample_generator_unit_test.sv */
// Testbench top for the waveform sample generator: stimulus, config phases, verdict.
module standard_waveform_sample_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_wave_type = '0;
  logic [11:0] in_sample_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample_value;
  logic [1:0] out_status;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit calm = 1'b0;      // no idling in the closing part
  bit hold_off = 1'b0;  // long receiver stall request
  logic [12:0] cur_length = 13'd64;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  standard_waveform_sample_generator_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_wave_type(in_wave_type),
    .in_sample_index(in_sample_index), .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_value(out_sample_value), .out_status(out_status)
  );

  standard_waveform_sample_generator_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_wave_type(in_wave_type),
    .in_sample_index(in_sample_index), .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_value(out_sample_value), .out_status(out_status),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: random stall bursts, long hold-off on request
  always begin
    @(negedge clk);
    if (hold_off) begin
      out_ready <= 1'b0;
      repeat (60) @(negedge clk);
      hold_off = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one word and wait for its acceptance
  task automatic send_word(logic [2:0] wtype, logic [11:0] idx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_wave_type <= wtype;
    in_sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait for all results, then write table length
  task automatic set_length(logic [12:0] len);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_length = (len > swsg_pkg::MAX_TABLE_LENGTH) ? swsg_pkg::MAX_TABLE_LENGTH : len;
  endtask

  // mostly in-range indexes, some out of range, occasional unknown types
  task automatic random_words(int count);
    logic [2:0] wtype;
    logic [11:0] idx;
    repeat (count) begin
      wtype = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      if (cur_length != 0 && $urandom_range(0, 9) != 0)
        idx = 12'($urandom_range(0, cur_length > 4096 ? 4095 : cur_length - 1));
      else
        idx = 12'($urandom);
      send_word(wtype, idx);
    end
  endtask

  initial begin
    logic [12:0] lengths[8] = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd3, 13'd1000,
                                13'd4095, 13'd64};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every type at edges and quarter points, default length
    for (int t = 0; t < 8; t++) send_word(3'(t), 12'd0);
    send_word(swsg_pkg::WAVE_SINE, 12'd16);
    send_word(swsg_pkg::WAVE_SINE, 12'd48);
    send_word(swsg_pkg::WAVE_SQUARE, 12'd31);
    send_word(swsg_pkg::WAVE_SQUARE, 12'd32);
    send_word(swsg_pkg::WAVE_TRIANGLE, 12'd32);
    send_word(swsg_pkg::WAVE_SAW_DOWN, 12'd63);
    send_word(swsg_pkg::WAVE_SAW_UP, 12'd63);
    send_word(swsg_pkg::WAVE_SAW_UP, 12'd64);
    send_word(swsg_pkg::WAVE_TRIANGLE, 12'd4095);
    send_word(3'd7, 12'd4095);

    // random phases over several lengths, extremes included
    foreach (lengths[k]) begin
      set_length(lengths[k]);
      if (k == 1) begin
        hold_off = 1'b1;
        random_words(120);
      end
      if (k == 7) calm = 1'b1;
      random_words(k == 1 ? 400 : 200);
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/swsg_pkg.sv
rtl/core/swsg_div.sv
rtl/core/standard_waveform_sample_generator_unit.sv
tb/standard_waveform_sample_generator_unit_checker.sv
tb/standard_waveform_sample_generator_unit_test.sv
